// ===== sv/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the line / rectangle clip unit.
// ----------------------------------------------------------------------------
package lrc_pkg;

   // fixed point format of all coordinates and coefficients
   localparam int FRAC_BITS = 16;

   // long division: 32 quotient bits, 4 per pipeline stage
   localparam int DIV_BITS       = 32;
   localparam int DIV_PER_STAGE  = 4;
   localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // edge order
   typedef enum logic [1:0] {
      EDGE_BOTTOM = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_TOP    = 2'd2,
      EDGE_LEFT   = 2'd3
   } lrc_edge_type;

   typedef struct packed {
      logic signed [31:0] line_a;
      logic signed [31:0] line_b;
      logic signed [31:0] line_c;
      logic signed [31:0] rect_x0;
      logic signed [31:0] rect_y0;
      logic signed [31:0] rect_x1;
      logic signed [31:0] rect_y1;
   } lrc_req_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
   } lrc_rsp_type;

   // one crossing to be solved by the back end
   typedef struct packed {
      logic               x_var;   // varying coordinate is x
      logic signed [31:0] fixed;   // copied coordinate
      logic [63:0]        num;     // |k|
      logic [31:0]        den;     // |coefficient|
      logic               neg;     // result is negative when nonzero
   } lrc_slot_type;

   // one queued job: classification plus the two crossings
   typedef struct packed {
      logic                    valid_res;
      lrc_slot_type [1:0]      slot;   // slot[0] is first in edge order
   } lrc_job_type;

   // one divider lane in flight
   typedef struct packed {
      logic               x_var;
      logic signed [31:0] fixed;
      logic [31:0]        den;
      logic [31:0]        rem;
      logic [31:0]        low;
      logic [31:0]        quo;
      logic               ovf;
      logic               neg;
   } lrc_lane_type;

   // saturate the signed quotient -(k)/lc into 32 bits
   function automatic logic [31:0] lrc_saturate(input logic ovf, input logic neg,
                                                input logic [31:0] quo);
      logic [31:0] res;
      if (neg) begin
         res = (ovf || quo[31]) ? 32'h8000_0000 : (32'd0 - quo);
      end else begin
         res = (ovf || quo[31]) ? 32'h7FFF_FFFF : quo;
      end
      return res;
   endfunction

endpackage

// ===== sv/line_rectangle_clip_unit.sv =====
// ----------------------------------------------------------------------------
// line_rectangle_clip_unit
// Clips a line a*x+b*y+c=0 against an axis-aligned rectangle, Q16.16.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  request | req_valid, req_stall, req_data     | in
//  result  | rsp_valid, rsp_stall, rsp_data     | out
//
// One transaction per clock is sustained unless the result stalls; the path
// goes through 3 classify stages, queue, setup, 8 divide stages, result.
// The divider pipeline resolves 4 quotient bits per stage.
// Reset is synchronous and clears only valid bits, queue pointers and count.
// A result stall holds the back end; the 4-entry queue lets the front end
// keep taking requests until it fills.
// ----------------------------------------------------------------------------
module line_rectangle_clip_unit import lrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lrc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lrc_rsp_type rsp_data
);

   logic        push, pop, full, empty;
   lrc_job_type push_job, pop_job;

   lrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_job   (push_job),
      .queue_full (full)
   );

   lrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_job  (pop_job)
   );

   lrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/lrc_front.sv =====
// ----------------------------------------------------------------------------
// lrc_front
// Takes clip requests, forms side values and classifies every edge of the rectangle.
// Emits one job per request with the two crossed edges set up for division.
// ----------------------------------------------------------------------------
module lrc_front import lrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lrc_req_type req_data,
   output logic        push,
   output lrc_job_type push_job,
   input  logic        queue_full
);

   logic en;

   // stage 1: products
   logic               s1_vld_ff;
   logic signed [63:0] pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   lrc_req_type        s1_req_ff;

   // stage 2: fixed terms plus scaled constant
   logic               s2_vld_ff;
   logic signed [63:0] s2_pa0_ff, s2_pa1_ff, s2_pb0_ff, s2_pb1_ff;
   logic signed [63:0] k_ff [4];
   lrc_req_type        s2_req_ff;

   // stage 3: hits
   logic               s3_vld_ff;
   logic [3:0]         hit_ff;
   logic signed [63:0] s3_k_ff [4];
   lrc_req_type        s3_req_ff;

   logic signed [63:0] cs;
   logic [3:0]         hit_in;
   logic signed [63:0] side_p [4][2];

   assign en        = !(s3_vld_ff && queue_full);
   assign req_stall = !en;
   assign push      = s3_vld_ff && !queue_full;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // stage 1 multipliers
   always_ff @(posedge clock) begin
      if (en) begin
         pa0_ff    <= 64'(req_data.line_a) * 64'(req_data.rect_x0);
         pa1_ff    <= 64'(req_data.line_a) * 64'(req_data.rect_x1);
         pb0_ff    <= 64'(req_data.line_b) * 64'(req_data.rect_y0);
         pb1_ff    <= 64'(req_data.line_b) * 64'(req_data.rect_y1);
         s1_req_ff <= req_data;
      end
   end

   assign cs = 64'(s1_req_ff.line_c) <<< FRAC_BITS;

   // stage 2 constant terms
   always_ff @(posedge clock) begin
      if (en) begin
         k_ff[EDGE_BOTTOM] <= pb0_ff + cs;
         k_ff[EDGE_RIGHT]  <= pa1_ff + cs;
         k_ff[EDGE_TOP]    <= pb1_ff + cs;
         k_ff[EDGE_LEFT]   <= pa0_ff + cs;
         s2_pa0_ff <= pa0_ff;
         s2_pa1_ff <= pa1_ff;
         s2_pb0_ff <= pb0_ff;
         s2_pb1_ff <= pb1_ff;
         s2_req_ff <= s1_req_ff;
      end
   end

   // endpoint terms of each edge along its varying coordinate
   always_comb begin
      side_p[EDGE_BOTTOM][0] = s2_pa0_ff;
      side_p[EDGE_BOTTOM][1] = s2_pa1_ff;
      side_p[EDGE_RIGHT][0]  = s2_pb0_ff;
      side_p[EDGE_RIGHT][1]  = s2_pb1_ff;
      side_p[EDGE_TOP][0]    = s2_pa1_ff;
      side_p[EDGE_TOP][1]    = s2_pa0_ff;
      side_p[EDGE_LEFT][0]   = s2_pb1_ff;
      side_p[EDGE_LEFT][1]   = s2_pb0_ff;
   end

   // exact sign of both endpoint side values, strict crossing test
   always_comb begin
      logic [64:0] s0, s1;
      logic        n0, n1, p0, p1;
      for (int e = 0; e < 4; e++) begin
         s0 = {side_p[e][0][63], side_p[e][0]} + {k_ff[e][63], k_ff[e]};
         s1 = {side_p[e][1][63], side_p[e][1]} + {k_ff[e][63], k_ff[e]};
         n0 = s0[64];
         n1 = s1[64];
         p0 = !s0[64] && (s0 != 65'd0);
         p1 = !s1[64] && (s1 != 65'd0);
         hit_in[e] = (n0 && p1) || (p0 && n1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff    <= hit_in;
         s3_k_ff   <= k_ff;
         s3_req_ff <= s2_req_ff;
      end
   end

   // pick the first and last crossed edge and set up their divisions
   always_comb begin
      lrc_edge_type e_sel;
      logic [1:0]   first_e, second_e;
      logic signed [63:0] kv;
      logic signed [31:0] lc;
      first_e  = 2'd0;
      second_e = 2'd0;
      for (int e = 3; e >= 0; e--) begin
         if (hit_ff[e]) first_e = 2'(e);
      end
      for (int e = 0; e < 4; e++) begin
         if (hit_ff[e]) second_e = 2'(e);
      end
      push_job.valid_res = ($countones(hit_ff) == 2);
      for (int j = 0; j < 2; j++) begin
         e_sel = lrc_edge_type'((j == 0) ? first_e : second_e);
         kv    = s3_k_ff[e_sel];
         unique case (e_sel)
            EDGE_BOTTOM: begin
               lc = s3_req_ff.line_a;
               push_job.slot[j].x_var = 1'b1;
               push_job.slot[j].fixed = s3_req_ff.rect_y0;
            end
            EDGE_RIGHT: begin
               lc = s3_req_ff.line_b;
               push_job.slot[j].x_var = 1'b0;
               push_job.slot[j].fixed = s3_req_ff.rect_x1;
            end
            EDGE_TOP: begin
               lc = s3_req_ff.line_a;
               push_job.slot[j].x_var = 1'b1;
               push_job.slot[j].fixed = s3_req_ff.rect_y1;
            end
            EDGE_LEFT: begin
               lc = s3_req_ff.line_b;
               push_job.slot[j].x_var = 1'b0;
               push_job.slot[j].fixed = s3_req_ff.rect_x0;
            end
            default: begin
               lc = s3_req_ff.line_a;
               push_job.slot[j].x_var = 1'b1;
               push_job.slot[j].fixed = s3_req_ff.rect_y0;
            end
         endcase
         push_job.slot[j].num = kv[63] ? (64'd0 - kv) : kv;
         push_job.slot[j].den = lc[31] ? (32'd0 - lc) : lc;
         push_job.slot[j].neg = (kv[63] == lc[31]);
      end
   end

endmodule

// ===== sv/lrc_queue.sv =====
// ----------------------------------------------------------------------------
// lrc_queue
// Short job queue between the classifier front end and the divider back end.
// ----------------------------------------------------------------------------
module lrc_queue import lrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  lrc_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output lrc_job_type pop_job
);

   lrc_job_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, rd_ff;
   logic [QUEUE_AW:0]   cnt_ff;

   assign full    = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// ===== sv/lrc_back.sv =====
// ----------------------------------------------------------------------------
// lrc_back
// Pipelined long division for the two crossings, saturation and result
// register.
// ----------------------------------------------------------------------------
module lrc_back import lrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  lrc_job_type pop_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lrc_rsp_type rsp_data
);

   logic         en;
   logic         vld_ff  [DIV_STAGES+1];
   logic         vres_ff [DIV_STAGES+1];
   lrc_lane_type lane_ff [DIV_STAGES+1][2];
   lrc_lane_type lane_in [DIV_STAGES][2];
   logic         out_vld_ff;
   lrc_rsp_type  out_ff;
   lrc_rsp_type  out_in;

   assign en        = !(out_vld_ff && rsp_stall);
   assign pop       = en && !empty;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // valid bits along the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) vld_ff[s] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !empty;
         for (int s = 1; s <= DIV_STAGES; s++) vld_ff[s] <= vld_ff[s-1];
         out_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   // setup: overflow check on the upper half, remainder seeded with it
   always_ff @(posedge clock) begin
      if (en) begin
         vres_ff[0] <= pop_job.valid_res;
         for (int j = 0; j < 2; j++) begin
            lane_ff[0][j].x_var <= pop_job.slot[j].x_var;
            lane_ff[0][j].fixed <= pop_job.slot[j].fixed;
            lane_ff[0][j].den   <= pop_job.slot[j].den;
            lane_ff[0][j].rem   <= pop_job.slot[j].num[63:32];
            lane_ff[0][j].low   <= pop_job.slot[j].num[31:0];
            lane_ff[0][j].quo   <= '0;
            lane_ff[0][j].ovf   <= (pop_job.slot[j].num[63:32] >= pop_job.slot[j].den);
            lane_ff[0][j].neg   <= pop_job.slot[j].neg;
         end
      end
   end

   // restoring division, 4 quotient bits per stage
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      always_comb begin
         logic [32:0] r33;
         for (int j = 0; j < 2; j++) begin
            lane_in[s][j] = lane_ff[s][j];
            for (int b = 0; b < DIV_PER_STAGE; b++) begin
               r33 = {lane_in[s][j].rem, lane_in[s][j].low[31]};
               lane_in[s][j].low = lane_in[s][j].low << 1;
               if (r33 >= {1'b0, lane_in[s][j].den}) begin
                  lane_in[s][j].rem = 32'(r33 - {1'b0, lane_in[s][j].den});
                  lane_in[s][j].quo = {lane_in[s][j].quo[30:0], 1'b1};
               end else begin
                  lane_in[s][j].rem = r33[31:0];
                  lane_in[s][j].quo = {lane_in[s][j].quo[30:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[s+1] <= lane_in[s];
            vres_ff[s+1] <= vres_ff[s];
         end
      end
   end

   // saturate and place coordinates; zeros when not exactly two crossings
   always_comb begin
      logic [31:0] v0, v1;
      lrc_lane_type l0, l1;
      l0 = lane_ff[DIV_STAGES][0];
      l1 = lane_ff[DIV_STAGES][1];
      v0 = lrc_saturate(l0.ovf, l0.neg, l0.quo);
      v1 = lrc_saturate(l1.ovf, l1.neg, l1.quo);
      out_in = '0;
      if (vres_ff[DIV_STAGES]) begin
         out_in.valid_res = 1'b1;
         out_in.first_x   = l0.x_var ? v0 : l0.fixed;
         out_in.first_y   = l0.x_var ? l0.fixed : v0;
         out_in.second_x  = l1.x_var ? v1 : l1.fixed;
         out_in.second_y  = l1.x_var ? l1.fixed : v1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

endmodule
